@@ hw/rtl/wce_pkg.sv @@
// wce_pkg: widths, limits and divider request/response types for the
// wachpress coordinates engine; no dependencies
package wce_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int CRD_W   = 16;
  localparam int DIF_W   = 17;
  localparam int MUL_W   = 36;
  localparam int PRD_W   = 2 * MUL_W;
  localparam int DVD_W   = 83;
  localparam int DEN_W   = 70;
  localparam int Q_W     = 48;
  localparam int DCNT_W  = 7;
  localparam int RAW_W   = 48;
  localparam int SUM_W   = 52;
  localparam int WGT_W   = 32;
  localparam int STP_W   = 4;

  localparam logic [CNT_W-1:0] N_MIN = CNT_W'(3);
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] N_RST = CNT_W'(4);

  localparam logic [WGT_W-1:0] Q30_ONE = WGT_W'(32'h4000_0000);
  localparam logic [Q_W-1:0]   RAW_POS_LIM = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0]   RAW_NEG_LIM = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [Q_W-1:0]   WGT_POS_LIM = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0]   WGT_NEG_LIM = Q_W'(32'h8000_0000);
  localparam logic signed [SUM_W-1:0] SUM_POS_LIM = SUM_W'(RAW_POS_LIM);
  localparam logic signed [SUM_W-1:0] SUM_NEG_LIM = -SUM_W'(RAW_NEG_LIM);
  localparam logic signed [MUL_W-1:0] TOL_ROOT = MUL_W'(1000);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dvd;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
    logic           ovf;
  } div_rsp_t;

  // signed difference of two q4.12 coordinates
  function automatic logic signed [DIF_W-1:0] sdiff(input logic [CRD_W-1:0] a,
                                                     input logic [CRD_W-1:0] b);
    sdiff = $signed({a[CRD_W-1], a}) - $signed({b[CRD_W-1], b});
  endfunction

  function automatic logic signed [MUL_W-1:0] sx(input logic signed [DIF_W-1:0] v);
    sx = MUL_W'(v);
  endfunction

endpackage

@@ hw/rtl/wce_div.sv @@
// wce_div: restoring radix-2 divider, one quotient bit per cycle,
// quotient kept to Q_W bits with a sticky overflow; uses wce_pkg
module wce_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wce_pkg::div_req_t  req,
  output wce_pkg::div_rsp_t  rsp
);
  import wce_pkg::*;

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              qbit;

  // trial subtract
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign qbit   = ~diff[DEN_W];

  always_comb begin
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt = req.dvd;
      den_nxt = req.den;
      rem_nxt = '0;
      quo_nxt = '0;
      ovf_nxt = 1'b0;
      cnt_nxt = DCNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      rem_nxt = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      ovf_nxt = ovf_r | quo_r[Q_W-1];
      quo_nxt = {quo_r[Q_W-2:0], qbit};
      cnt_nxt = cnt_r - DCNT_W'(1);
      done_nxt = (cnt_r == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.ovf  = ovf_r;

endmodule

@@ hw/rtl/wachpress_coordinates_engine_core.sv @@
// wachpress_coordinates_engine_core: polygon store, edge test and wachpress
// weights over one shared multiplier and one shared divider; uses wce_pkg, wce_div
//
// channel | direction | words
// in_     | input     | cmd, vertex_slot, coord_x, coord_y
// out_    | output    | weight_index, weight, on_edge, degenerate, last_weight
// cfg_    | input     | vertex_count
//
// a load writes the vertex store straight from idle; a query tests each edge
// in turn, then computes a raw weight per vertex with a divide (skipped when an
// angle term is zero), then normalizes each one with a divide (skipped when it
// or the sum is zero), and last delivers one result word per vertex.
// an edge hit costs at most one divide and then the result words.
// in_ready is high only between queries; a stalled out_ready holds the word.
// synchronous active-low reset clears control and sets vertex_count to 4.
module wachpress_coordinates_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [wce_pkg::IDX_W-1:0]           in_vertex_slot,
  input  logic signed [wce_pkg::CRD_W-1:0]    in_coord_x,
  input  logic signed [wce_pkg::CRD_W-1:0]    in_coord_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wce_pkg::IDX_W-1:0]           out_weight_index,
  output logic signed [wce_pkg::WGT_W-1:0]    out_weight,
  output logic                                out_on_edge,
  output logic                                out_degenerate,
  output logic                                out_last_weight,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wce_pkg::CNT_W-1:0]           cfg_vertex_count
);
  import wce_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_EDGE    = 10'b00_0000_0010,
    S_TDIV    = 10'b00_0000_0100,
    S_WACH    = 10'b00_0000_1000,
    S_RDIV    = 10'b00_0001_0000,
    S_SUM     = 10'b00_0010_0000,
    S_NORM    = 10'b00_0100_0000,
    S_NDIV    = 10'b00_1000_0000,
    S_EMIT_RD = 10'b01_0000_0000,
    S_EMIT_WT = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [STP_W-1:0] stp_r, stp_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] vcount_r;
  logic [CRD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [CRD_W-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [CRD_W-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [CRD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [MUL_W-1:0] acc_r, acc_nxt, num_r, num_nxt;
  logic signed [MUL_W-1:0] c1_r, c1_nxt, c2_r, c2_nxt;
  logic signed [MUL_W-1:0] l2_r, l2_nxt, dot_r, dot_nxt;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [MUL_W-1:0] ma, mb;
  logic [Q_W-2:0]   t_r, t_nxt;
  logic [IDX_W-1:0] ep_r, ep_nxt, ej_r, ej_nxt;
  logic             neg_r, neg_nxt;
  logic [Q_W-1:0]   lim_r, lim_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic             deg_r, deg_nxt, edge_r, edge_nxt;

  logic                    ov_r, ov_nxt;
  logic [IDX_W-1:0]        oi_r, oi_nxt;
  logic [WGT_W-1:0]        ow_r, ow_nxt;
  logic                    oe_r, oe_nxt, od_r, od_nxt, ol_r, ol_nxt;

  // vertex, raw weight and final weight stores
  logic [CRD_W-1:0] vx_mem [MAX_VERTICES];
  logic [CRD_W-1:0] vy_mem [MAX_VERTICES];
  logic [RAW_W-1:0] raw_mem [MAX_VERTICES];
  logic [WGT_W-1:0] w_mem [MAX_VERTICES];
  logic [CRD_W-1:0] vx_q, vy_q;
  logic [RAW_W-1:0] raw_q;
  logic [WGT_W-1:0] w_q;
  logic [IDX_W-1:0] rd_addr;
  logic             v_we, raw_we, w_we;
  logic [RAW_W-1:0] raw_wd;
  logic [WGT_W-1:0] w_wd;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [CNT_W-1:0] nm1, n_clamp;
  logic [IDX_W-1:0] p_idx, nx_idx;
  logic             last_j;
  logic signed [DIF_W-1:0] mx, my, xx, xy, ux, uy, wx, wy, rx, ry;
  logic [MUL_W-1:0] ucr, uc1, uc2;
  logic [Q_W-1:0]   qsat;
  logic             sat;
  logic [RAW_W-1:0] raw_v, raw_mag;
  logic [SUM_W-1:0] sum_mag;
  logic [WGT_W-1:0] edge_w;

  wce_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // ring indices
  assign nm1    = n_r - CNT_W'(1);
  assign last_j = (j_r == nm1[IDX_W-1:0]);
  assign p_idx  = (j_r == '0) ? nm1[IDX_W-1:0] : j_r - IDX_W'(1);
  assign nx_idx = last_j ? '0 : j_r + IDX_W'(1);
  assign n_clamp = (vcount_r < N_MIN) ? N_MIN : (vcount_r > N_MAX) ? N_MAX : vcount_r;

  // edge and corner differences
  assign mx = sdiff(bx_r, ax_r);
  assign my = sdiff(by_r, ay_r);
  assign xx = sdiff(px_r, ax_r);
  assign xy = sdiff(py_r, ay_r);
  assign ux = sdiff(ax_r, bx_r);
  assign uy = sdiff(ay_r, by_r);
  assign wx = sdiff(cx_r, bx_r);
  assign wy = sdiff(cy_r, by_r);
  assign rx = sdiff(px_r, bx_r);
  assign ry = sdiff(py_r, by_r);

  assign ucr = num_r[MUL_W-1] ? MUL_W'(-num_r) : MUL_W'(num_r);
  assign uc1 = c1_r[MUL_W-1] ? MUL_W'(-c1_r) : MUL_W'(c1_r);
  assign uc2 = c2_r[MUL_W-1] ? MUL_W'(-c2_r) : MUL_W'(c2_r);

  // divider result saturated to the current limit
  assign sat   = drsp.ovf || (drsp.quo > lim_r);
  assign qsat  = sat ? lim_r : drsp.quo;
  assign raw_v = neg_r ? -qsat : qsat;
  assign raw_mag = raw_q[RAW_W-1] ? -raw_q : raw_q;
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  assign edge_w = (j_r == ep_r) ? (Q30_ONE - WGT_W'(t_r)) :
                  (j_r == ej_r) ? WGT_W'(t_r) : '0;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    stp_nxt = stp_r + STP_W'(1);
    j_nxt = j_r;
    n_nxt = n_r;
    px_nxt = px_r; py_nxt = py_r;
    ax_nxt = ax_r; ay_nxt = ay_r;
    bx_nxt = bx_r; by_nxt = by_r;
    cx_nxt = cx_r; cy_nxt = cy_r;
    acc_nxt = acc_r; num_nxt = num_r;
    c1_nxt = c1_r; c2_nxt = c2_r;
    l2_nxt = l2_r; dot_nxt = dot_r;
    t_nxt = t_r; ep_nxt = ep_r; ej_nxt = ej_r;
    neg_nxt = neg_r; lim_nxt = lim_r;
    sum_nxt = sum_r;
    deg_nxt = deg_r; edge_nxt = edge_r;
    ov_nxt = ov_r; oi_nxt = oi_r; ow_nxt = ow_r;
    oe_nxt = oe_r; od_nxt = od_r; ol_nxt = ol_r;
    ma = '0; mb = '0;
    rd_addr = j_r;
    v_we = 1'b0;
    raw_we = 1'b0; raw_wd = '0;
    w_we = 1'b0; w_wd = '0;
    dreq.start = 1'b0;
    dreq.dvd = '0;
    dreq.den = '0;
    case (state_r)
      S_IDLE: begin
        stp_nxt = '0;
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            v_we = 1'b1;
          end else begin
            px_nxt = in_coord_x;
            py_nxt = in_coord_y;
            n_nxt = n_clamp;
            j_nxt = '0;
            deg_nxt = 1'b0;
            edge_nxt = 1'b0;
            sum_nxt = '0;
            state_nxt = S_EDGE;
          end
        end
      end
      // edge test for edge (prev, j)
      S_EDGE: begin
        case (stp_r)
          4'd0: rd_addr = p_idx;
          4'd1: begin
            ax_nxt = vx_q; ay_nxt = vy_q;
          end
          4'd2: begin
            bx_nxt = vx_q; by_nxt = vy_q;
          end
          4'd3: begin
            ma = sx(mx); mb = sx(xy);
          end
          4'd4: begin
            acc_nxt = prod_r[MUL_W-1:0];
            ma = sx(my); mb = sx(xx);
          end
          4'd5: begin
            num_nxt = acc_r - prod_r[MUL_W-1:0];
            ma = sx(mx); mb = sx(mx);
          end
          4'd6: begin
            l2_nxt = prod_r[MUL_W-1:0];
            ma = sx(my); mb = sx(my);
          end
          4'd7: begin
            l2_nxt = l2_r + prod_r[MUL_W-1:0];
            ma = sx(mx); mb = sx(xx);
          end
          4'd8: begin
            dot_nxt = prod_r[MUL_W-1:0];
            ma = sx(my); mb = sx(xy);
          end
          4'd9: begin
            dot_nxt = dot_r + prod_r[MUL_W-1:0];
            ma = MUL_W'(ucr[19:0]); mb = TOL_ROOT;
          end
          4'd10: begin
            ma = MUL_W'(prod_r[29:0]); mb = MUL_W'(prod_r[29:0]);
          end
          4'd11: begin
            stp_nxt = '0;
            if ((l2_r != '0) && (ucr[MUL_W-1:20] == '0) &&
                (prod_r[59:0] < {l2_r[33:0], 26'b0} >> 2)) begin
              edge_nxt = 1'b1;
              ep_nxt = p_idx;
              ej_nxt = j_r;
              j_nxt = '0;
              if (dot_r[MUL_W-1] || dot_r == '0) begin
                t_nxt = '0;
                state_nxt = S_EMIT_RD;
              end else if (dot_r >= l2_r) begin
                t_nxt = (Q_W-1)'(Q30_ONE);
                state_nxt = S_EMIT_RD;
              end else begin
                dreq.start = 1'b1;
                dreq.dvd = DVD_W'({dot_r[33:0], 30'b0});
                dreq.den = DEN_W'(l2_r);
                state_nxt = S_TDIV;
              end
            end else if (last_j) begin
              j_nxt = '0;
              state_nxt = S_WACH;
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
          default: stp_nxt = '0;
        endcase
      end
      S_TDIV: begin
        stp_nxt = '0;
        if (drsp.done) begin
          t_nxt = drsp.quo[Q_W-2:0];
          state_nxt = S_EMIT_RD;
        end
      end
      // wachpress raw weight for vertex j
      S_WACH: begin
        case (stp_r)
          4'd0: rd_addr = p_idx;
          4'd1: begin
            ax_nxt = vx_q; ay_nxt = vy_q;
            rd_addr = j_r;
          end
          4'd2: begin
            bx_nxt = vx_q; by_nxt = vy_q;
            rd_addr = nx_idx;
          end
          4'd3: begin
            cx_nxt = vx_q; cy_nxt = vy_q;
          end
          4'd4: begin
            ma = sx(wx); mb = sx(uy);
          end
          4'd5: begin
            acc_nxt = prod_r[MUL_W-1:0];
            ma = sx(wy); mb = sx(ux);
          end
          4'd6: begin
            num_nxt = acc_r - prod_r[MUL_W-1:0];
            ma = sx(rx); mb = sx(uy);
          end
          4'd7: begin
            acc_nxt = prod_r[MUL_W-1:0];
            ma = sx(ry); mb = sx(ux);
          end
          4'd8: begin
            c1_nxt = acc_r - prod_r[MUL_W-1:0];
            ma = sx(wx); mb = sx(ry);
          end
          4'd9: begin
            acc_nxt = prod_r[MUL_W-1:0];
            ma = sx(wy); mb = sx(rx);
          end
          4'd10: c2_nxt = acc_r - prod_r[MUL_W-1:0];
          4'd11: begin
            if (c1_r == '0 || c2_r == '0) begin
              deg_nxt = 1'b1;
              raw_we = 1'b1;
              raw_wd = '0;
              stp_nxt = '0;
              if (last_j) begin
                state_nxt = S_SUM;
              end else begin
                j_nxt = j_r + IDX_W'(1);
              end
            end else begin
              ma = $signed(uc1); mb = $signed(uc2);
              neg_nxt = num_r[MUL_W-1] ^ c1_r[MUL_W-1] ^ c2_r[MUL_W-1];
              lim_nxt = (num_r[MUL_W-1] ^ c1_r[MUL_W-1] ^ c2_r[MUL_W-1]) ?
                        RAW_NEG_LIM : RAW_POS_LIM;
            end
          end
          4'd12: begin
            stp_nxt = '0;
            dreq.start = 1'b1;
            dreq.dvd = {ucr[34:0], 48'b0};
            dreq.den = prod_r[DEN_W-1:0];
            state_nxt = S_RDIV;
          end
          default: stp_nxt = '0;
        endcase
      end
      S_RDIV: begin
        stp_nxt = '0;
        if (drsp.done) begin
          raw_we = 1'b1;
          raw_wd = raw_v;
          sum_nxt = sum_r + SUM_W'($signed(raw_v));
          deg_nxt = deg_r | sat;
          if (last_j) begin
            state_nxt = S_SUM;
          end else begin
            j_nxt = j_r + IDX_W'(1);
            state_nxt = S_WACH;
          end
        end
      end
      // clamp the sum to the raw range
      S_SUM: begin
        stp_nxt = '0;
        j_nxt = '0;
        state_nxt = S_NORM;
        if (sum_r > SUM_POS_LIM) begin
          sum_nxt = SUM_POS_LIM;
          deg_nxt = 1'b1;
        end else if (sum_r < SUM_NEG_LIM) begin
          sum_nxt = SUM_NEG_LIM;
          deg_nxt = 1'b1;
        end
      end
      // normalize raw weight j by the sum
      S_NORM: begin
        if (stp_r != '0) begin
          stp_nxt = '0;
          if (sum_r == '0 || raw_q == '0) begin
            deg_nxt = deg_r | (sum_r == '0);
            w_we = 1'b1;
            w_wd = '0;
            if (last_j) begin
              j_nxt = '0;
              state_nxt = S_EMIT_RD;
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end else begin
            neg_nxt = raw_q[RAW_W-1] ^ sum_r[SUM_W-1];
            lim_nxt = (raw_q[RAW_W-1] ^ sum_r[SUM_W-1]) ? WGT_NEG_LIM : WGT_POS_LIM;
            dreq.start = 1'b1;
            dreq.dvd = DVD_W'({raw_mag, 30'b0});
            dreq.den = DEN_W'(sum_mag[RAW_W-1:0]);
            state_nxt = S_NDIV;
          end
        end
      end
      S_NDIV: begin
        stp_nxt = '0;
        if (drsp.done) begin
          w_we = 1'b1;
          w_wd = raw_v[WGT_W-1:0];
          deg_nxt = deg_r | sat;
          if (last_j) begin
            j_nxt = '0;
            state_nxt = S_EMIT_RD;
          end else begin
            j_nxt = j_r + IDX_W'(1);
            state_nxt = S_NORM;
          end
        end
      end
      // result words, one per vertex
      S_EMIT_RD: begin
        if (stp_r != '0) begin
          stp_nxt = '0;
          ov_nxt = 1'b1;
          oi_nxt = j_r;
          ow_nxt = edge_r ? edge_w : w_q;
          oe_nxt = edge_r;
          od_nxt = edge_r ? 1'b0 : deg_r;
          ol_nxt = last_j;
          state_nxt = S_EMIT_WT;
        end
      end
      S_EMIT_WT: begin
        stp_nxt = '0;
        if (out_ready) begin
          ov_nxt = 1'b0;
          if (last_j) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt = j_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        stp_nxt = '0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      stp_r    <= '0;
      j_r      <= '0;
      n_r      <= N_RST;
      vcount_r <= N_RST;
      ov_r     <= 1'b0;
      deg_r    <= 1'b0;
      edge_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stp_r   <= stp_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
      deg_r   <= deg_nxt;
      edge_r  <= edge_nxt;
      if (cfg_valid) begin
        vcount_r <= cfg_vertex_count;
      end
    end
  end

  // datapath registers and shared multiplier
  always_ff @(posedge clk) begin
    px_r <= px_nxt; py_r <= py_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt;
    acc_r <= acc_nxt; num_r <= num_nxt;
    c1_r <= c1_nxt; c2_r <= c2_nxt;
    l2_r <= l2_nxt; dot_r <= dot_nxt;
    t_r <= t_nxt; ep_r <= ep_nxt; ej_r <= ej_nxt;
    neg_r <= neg_nxt; lim_r <= lim_nxt;
    sum_r <= sum_nxt;
    oi_r <= oi_nxt; ow_r <= ow_nxt;
    oe_r <= oe_nxt; od_r <= od_nxt; ol_r <= ol_nxt;
    prod_r <= ma * mb;
  end

  // stores
  always_ff @(posedge clk) begin
    if (v_we) begin
      vx_mem[in_vertex_slot] <= in_coord_x;
      vy_mem[in_vertex_slot] <= in_coord_y;
    end
    if (raw_we) begin
      raw_mem[j_r] <= raw_wd;
    end
    if (w_we) begin
      w_mem[j_r] <= w_wd;
    end
    vx_q  <= vx_mem[rd_addr];
    vy_q  <= vy_mem[rd_addr];
    raw_q <= raw_mem[j_r];
    w_q   <= w_mem[j_r];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_weight_index = oi_r;
  assign out_weight = ow_r;
  assign out_on_edge = oe_r;
  assign out_degenerate = od_r;
  assign out_last_weight = ol_r;

endmodule

@@ hw/rtl/wce_chk.sv @@
// wce_chk: port-level checks for the wachpress coordinates engine, bound
// to the top level; uses wce_pkg
module wce_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [wce_pkg::IDX_W-1:0]          out_weight_index,
  input logic signed [wce_pkg::WGT_W-1:0]   out_weight,
  input logic                               out_on_edge,
  input logic                               out_degenerate,
  input logic                               out_last_weight
);
  import wce_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_weight) &&
    $stable(out_weight_index))
    else $error("stalled result word changed");

  // no new item while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // more words follow a non-final word
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_weight |=> !in_ready)
    else $error("query ended before its last word");

  // final word ends the query
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_weight |=> !out_valid)
    else $error("word after final word");

  // edge weights never flag degenerate
  a_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_on_edge |-> !out_degenerate)
    else $error("edge word flagged degenerate");

endmodule

bind wachpress_coordinates_engine_core wce_chk u_wce_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_weight_index(out_weight_index),
  .out_weight(out_weight),
  .out_on_edge(out_on_edge),
  .out_degenerate(out_degenerate),
  .out_last_weight(out_last_weight)
);
